FILE: design/jvc_pkg.sv
package jvc_pkg;

   localparam int MaxDepthDefault = 64;
   localparam int FifoDepth       = 4;

   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChLbrace = 8'h7B;
   localparam logic [7:0] ChRbrace = 8'h7D;
   localparam logic [7:0] ChLbrack = 8'h5B;
   localparam logic [7:0] ChRbrack = 8'h5D;
   localparam logic [7:0] ChComma  = 8'h2C;
   localparam logic [7:0] ChColon  = 8'h3A;
   localparam logic [7:0] ChMinus  = 8'h2D;
   localparam logic [7:0] ChPlus   = 8'h2B;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChSpace  = 8'h20;

   localparam logic [1:0] LitTrue  = 2'd0;
   localparam logic [1:0] LitFalse = 2'd1;
   localparam logic [1:0] LitNull  = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_verdict;
      logic       doc_valid;
      logic       run_last;
   } rsp_item_type;

   // up to two results per input beat; count says how many of first/second are live
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_pair_type;

   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      logic [2:0] len;
      unique case (kind)
         LitTrue:  len = 3'd4;
         LitFalse: len = 3'd5;
         LitNull:  len = 3'd4;
         default:  len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (kind)
         LitTrue: begin
            unique case (pos)
               3'd0:    ch = "t";
               3'd1:    ch = "r";
               3'd2:    ch = "u";
               3'd3:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LitFalse: begin
            unique case (pos)
               3'd0:    ch = "f";
               3'd1:    ch = "a";
               3'd2:    ch = "l";
               3'd3:    ch = "s";
               3'd4:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LitNull: begin
            unique case (pos)
               3'd0:    ch = "n";
               3'd1:    ch = "u";
               3'd2:    ch = "l";
               3'd3:    ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: design/jvc_ram.sv
module jvc_ram #(
   parameter int  Width = 1,
   parameter int  Depth = 64,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/jvc_parser.sv
module jvc_parser #(
   parameter int MaxDepth = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           in_byte,
   input  logic                 is_last,
   output jvc_pkg::rsp_pair_type results
);

   import jvc_pkg::*;

   localparam int DepW  = $clog2(MaxDepth + 1);
   localparam int AddrW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

   typedef enum logic [4:0] {
      PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_KEY, PH_COLON, PH_AFTER,
      PH_VSTR, PH_VESC, PH_VHEX, PH_KSTR, PH_KESC, PH_KHEX, PH_LIT,
      PH_MINUS, PH_ZERO, PH_INT, PH_DOT, PH_FRAC, PH_EXP_MARK, PH_EXP_SIGN,
      PH_EXP
   } phase_type;

   phase_type       phase_ff, phase_in, phase_nxt;
   logic [DepW-1:0] depth_ff, depth_in, depth_nxt, rd_ptr;
   logic            tos_ff, tos_in;        // kind of innermost container, 1 object
   logic [2:0]      lit_pos_ff, lit_pos_in;
   logic [1:0]      lit_kind_ff, lit_kind_in;
   logic [1:0]      hex_left_ff, hex_left_in;
   logic            err_ff;

   logic            below;                 // entry under the top, prefetched
   logic            push, push_kind;
   logic            echo, err;
   logic            do_start, do_after, do_close, close_kind;
   logic            ws, dig, hex, is_e, key;
   logic            apply, echo_fire, err_after, complete;
   logic [7:0]      c;
   logic [2:0]      lit_pos_inc;
   rsp_item_type    echo_item, verdict_item;

   assign c    = in_byte;
   assign ws   = (c == ChSpace) || (c >= 8'h09 && c <= 8'h0D);
   assign dig  = (c >= ChZero) && (c <= ChNine);
   assign hex  = dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   assign is_e = (c == "e") || (c == "E");
   assign key  = (phase_ff == PH_KSTR) || (phase_ff == PH_KESC) || (phase_ff == PH_KHEX);
   assign lit_pos_inc = lit_pos_ff + 3'd1;

   always_comb begin
      echo        = 1'b0;
      err         = 1'b0;
      do_start    = 1'b0;
      do_after    = 1'b0;
      do_close    = 1'b0;
      close_kind  = 1'b0;
      push        = 1'b0;
      push_kind   = 1'b0;
      phase_in    = phase_ff;
      depth_in    = depth_ff;
      tos_in      = tos_ff;
      lit_pos_in  = lit_pos_ff;
      lit_kind_in = lit_kind_ff;
      hex_left_in = hex_left_ff;

      unique case (phase_ff)
         PH_VALUE: do_start = 1'b1;
         PH_ARR_FIRST: begin
            if (c == ChRbrack) begin
               do_close = 1'b1;
            end else begin
               do_start = 1'b1;
            end
         end
         PH_OBJ_FIRST, PH_KEY: begin
            if (phase_ff == PH_OBJ_FIRST && c == ChRbrace) begin
               do_close   = 1'b1;
               close_kind = 1'b1;
            end else if (ws) begin
               echo = 1'b0;
            end else if (c == ChQuote) begin
               phase_in = PH_KSTR;
               echo     = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_COLON: begin
            if (c == ChColon) begin
               phase_in = PH_VALUE;
               echo     = 1'b1;
            end else if (!ws) begin
               err = 1'b1;
            end
         end
         PH_AFTER: do_after = 1'b1;
         PH_VSTR, PH_KSTR: begin
            if (c == ChQuote) begin
               phase_in = key ? PH_COLON : PH_AFTER;
               echo     = 1'b1;
            end else if (c == ChBslash) begin
               phase_in = key ? PH_KESC : PH_VESC;
               echo     = 1'b1;
            end else if (c < 8'h20) begin
               err = 1'b1;
            end else begin
               echo = 1'b1;
            end
         end
         PH_VESC, PH_KESC: begin
            if (c == ChQuote || c == ChBslash || c == ChSlash || c == "b" || c == "f"
                || c == "n" || c == "r" || c == "t") begin
               phase_in = key ? PH_KSTR : PH_VSTR;
               echo     = 1'b1;
            end else if (c == "u") begin
               hex_left_in = 2'd3;
               phase_in    = key ? PH_KHEX : PH_VHEX;
               echo        = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_VHEX, PH_KHEX: begin
            if (!hex) begin
               err = 1'b1;
            end else begin
               echo = 1'b1;
               if (hex_left_ff == 2'd0) begin
                  phase_in = key ? PH_KSTR : PH_VSTR;
               end else begin
                  hex_left_in = hex_left_ff - 2'd1;
               end
            end
         end
         PH_LIT: begin
            if (lit_pos_ff >= lit_len(lit_kind_ff)) begin
               err = 1'b1;
            end else if (c != lit_char(lit_kind_ff, lit_pos_ff)) begin
               err = 1'b1;
            end else begin
               echo = 1'b1;
               if (lit_pos_inc == lit_len(lit_kind_ff)) begin
                  lit_pos_in = 3'd0;
                  phase_in   = PH_AFTER;
               end else begin
                  lit_pos_in = lit_pos_inc;
               end
            end
         end
         PH_MINUS: begin
            if (c == ChZero) begin
               phase_in = PH_ZERO;
               echo     = 1'b1;
            end else if (dig) begin
               phase_in = PH_INT;
               echo     = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_ZERO, PH_INT: begin
            if (dig) begin
               // no leading zeros
               err  = (phase_ff == PH_ZERO);
               echo = (phase_ff != PH_ZERO);
            end else if (c == ChDot) begin
               phase_in = PH_DOT;
               echo     = 1'b1;
            end else if (is_e) begin
               phase_in = PH_EXP_MARK;
               echo     = 1'b1;
            end else begin
               do_after = 1'b1;
            end
         end
         PH_DOT: begin
            if (dig) begin
               phase_in = PH_FRAC;
               echo     = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_FRAC: begin
            if (dig) begin
               echo = 1'b1;
            end else if (is_e) begin
               phase_in = PH_EXP_MARK;
               echo     = 1'b1;
            end else begin
               do_after = 1'b1;
            end
         end
         PH_EXP_MARK, PH_EXP_SIGN: begin
            if (phase_ff == PH_EXP_MARK && (c == ChPlus || c == ChMinus)) begin
               phase_in = PH_EXP_SIGN;
               echo     = 1'b1;
            end else if (dig) begin
               phase_in = PH_EXP;
               echo     = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_EXP: begin
            if (dig) begin
               echo = 1'b1;
            end else begin
               do_after = 1'b1;
            end
         end
         default: err = 1'b1;
      endcase

      if (do_start) begin
         if (ws) begin
            echo = 1'b0;
         end else if (c == ChLbrace || c == ChLbrack) begin
            if (depth_ff >= DepW'(MaxDepth)) begin
               err = 1'b1;
            end else begin
               push      = 1'b1;
               push_kind = (c == ChLbrace);
               depth_in  = depth_ff + DepW'(1);
               tos_in    = (c == ChLbrace);
               phase_in  = (c == ChLbrace) ? PH_OBJ_FIRST : PH_ARR_FIRST;
               echo      = 1'b1;
            end
         end else if (c == ChQuote) begin
            phase_in = PH_VSTR;
            echo     = 1'b1;
         end else if (c == "t" || c == "f" || c == "n") begin
            lit_kind_in = (c == "t") ? LitTrue : ((c == "f") ? LitFalse : LitNull);
            lit_pos_in  = 3'd1;
            phase_in    = PH_LIT;
            echo        = 1'b1;
         end else if (c == ChMinus) begin
            phase_in = PH_MINUS;
            echo     = 1'b1;
         end else if (c == ChZero) begin
            phase_in = PH_ZERO;
            echo     = 1'b1;
         end else if (dig) begin
            phase_in = PH_INT;
            echo     = 1'b1;
         end else begin
            err = 1'b1;
         end
      end

      if (do_after) begin
         phase_in = PH_AFTER;
         if (ws) begin
            echo = 1'b0;
         end else if (depth_ff == '0) begin
            err = 1'b1;
         end else if (c == ChComma) begin
            phase_in = tos_ff ? PH_KEY : PH_VALUE;
            echo     = 1'b1;
         end else if (c == ChRbrack) begin
            do_close = 1'b1;
         end else if (c == ChRbrace) begin
            do_close   = 1'b1;
            close_kind = 1'b1;
         end else begin
            err = 1'b1;
         end
      end

      if (do_close) begin
         if (depth_ff == '0 || tos_ff != close_kind) begin
            err = 1'b1;
         end else begin
            depth_in = depth_ff - DepW'(1);
            tos_in   = below;
            phase_in = PH_AFTER;
            echo     = 1'b1;
         end
      end
   end

   assign apply     = take && !err_ff && !err;
   assign echo_fire = apply && echo;
   assign err_after = err_ff || (take && err);

   always_comb begin
      if (take && is_last) begin
         phase_nxt = PH_VALUE;
         depth_nxt = '0;
      end else if (apply) begin
         phase_nxt = phase_in;
         depth_nxt = depth_in;
      end else begin
         phase_nxt = phase_ff;
         depth_nxt = depth_ff;
      end
   end

   // verdict judged on the state this byte leaves behind
   always_comb begin
      phase_type ph;
      logic [DepW-1:0] dp;
      ph = apply ? phase_in : phase_ff;
      dp = apply ? depth_in : depth_ff;
      complete = (dp == '0) && (ph == PH_AFTER || ph == PH_ZERO || ph == PH_INT
                                || ph == PH_FRAC || ph == PH_EXP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_VALUE;
         depth_ff    <= '0;
         lit_pos_ff  <= 3'd0;
         lit_kind_ff <= LitTrue;
         hex_left_ff <= 2'd0;
         err_ff      <= 1'b0;
      end else begin
         phase_ff <= phase_nxt;
         depth_ff <= depth_nxt;
         if (take && is_last) begin
            lit_pos_ff  <= 3'd0;
            lit_kind_ff <= LitTrue;
            hex_left_ff <= 2'd0;
            err_ff      <= 1'b0;
         end else if (take) begin
            if (apply) begin
               lit_pos_ff  <= lit_pos_in;
               lit_kind_ff <= lit_kind_in;
               hex_left_ff <= hex_left_in;
            end
            if (err) begin
               err_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         tos_ff <= tos_in;
      end
   end

   // keep the entry under the new top in flight so a close never waits
   assign rd_ptr = depth_nxt - DepW'(2);

   jvc_ram #(
      .Width (1),
      .Depth (MaxDepth)
   ) u_stack (
      .clock   (clock),
      .wr_en   (apply && push),
      .wr_addr (depth_ff[AddrW-1:0]),
      .wr_data (push_kind),
      .rd_addr (rd_ptr[AddrW-1:0]),
      .rd_data (below)
   );

   always_comb begin
      echo_item.out_byte     = c;
      echo_item.is_verdict   = 1'b0;
      echo_item.doc_valid    = 1'b0;
      echo_item.run_last     = !is_last;
      verdict_item.out_byte   = 8'h00;
      verdict_item.is_verdict = 1'b1;
      verdict_item.doc_valid  = !err_after && complete;
      verdict_item.run_last   = 1'b1;

      results.count  = {1'b0, echo_fire} + {1'b0, take && is_last};
      results.first  = echo_fire ? echo_item : verdict_item;
      results.second = verdict_item;
   end

endmodule

FILE: design/jvc_rsp_fifo.sv
module jvc_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  jvc_pkg::rsp_pair_type wr_pair,
   output logic                  room,
   output logic                  rd_valid,
   output jvc_pkg::rsp_item_type rd_item,
   input  logic                  rd_pop
);

   import jvc_pkg::*;

   localparam int PtrW = $clog2(FifoDepth);
   localparam int CntW = PtrW + 1;

   rsp_item_type    mem_ff [FifoDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff, wr_next;
   logic [CntW-1:0] count_ff;

   assign wr_next  = wr_ptr_ff + PtrW'(1);
   assign room     = count_ff <= CntW'(FifoDepth - 2);   // a beat may bring two results
   assign rd_valid = count_ff != '0;
   assign rd_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrW'(wr_pair.count);
         rd_ptr_ff <= rd_ptr_ff + PtrW'(rd_pop);
         count_ff  <= count_ff + CntW'(wr_pair.count) - CntW'(rd_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pair.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_pair.first;
      end
      if (wr_pair.count == 2'd2) begin
         mem_ff[wr_next] <= wr_pair.second;
      end
   end

endmodule

FILE: design/json_validate_compact.sv
// One document byte per cycle in; the nesting stack top is kept in a register and the
// entry below it is read ahead from the stack RAM, so closes never stall.
// Each accepted byte's results are registered into the result queue, read from its head.
// Throughput: 1 byte/cycle; the last byte adds a verdict beat after any echo.
// req_tready is low in reset or when the 4-entry queue lacks room for two beats.
// Reset: synchronous, active high; parser returns to expecting a top-level value.
module json_validate_compact #(
   parameter int MaxDepth = jvc_pkg::MaxDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] out_byte, [8] doc_valid, [15:9] zero
   output logic        rsp_tuser,    // is_verdict
   output logic        rsp_tlast     // run_last
);

   import jvc_pkg::*;

   logic         take;
   logic         room;
   rsp_pair_type pair;
   rsp_item_type head;

   // no beat is taken while reset is held
   assign req_tready = room && !reset;
   assign take       = req_tvalid && req_tready;

   jvc_parser #(
      .MaxDepth (MaxDepth)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_tdata),
      .is_last (req_tlast),
      .results (pair)
   );

   jvc_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_pair  (pair),
      .room     (room),
      .rd_valid (rsp_tvalid),
      .rd_item  (head),
      .rd_pop   (rsp_tvalid && rsp_tready)
   );

   assign rsp_tdata = {7'b0, head.doc_valid, head.out_byte};
   assign rsp_tuser = head.is_verdict;
   assign rsp_tlast = head.run_last;

endmodule

FILE: tb/tb_json_validate_compact.sv
module tb_json_validate_compact;
   timeunit 1ns;
   timeprecision 1ps;

   import jvc_pkg::*;

   localparam int NestMax     = MaxDepthDefault;
   localparam int StallLimit  = 2000;
   localparam int HoldCycles  = 300;
   localparam int RandomBytes = 120;

   typedef enum logic [4:0] {
      P_VALUE, P_ARR_FIRST, P_OBJ_FIRST, P_KEY, P_COLON, P_AFTER,
      P_VSTR, P_VESC, P_VHEX, P_KSTR, P_KESC, P_KHEX, P_LIT,
      P_MINUS, P_ZERO, P_INT, P_DOT, P_FRAC, P_EXP_MARK, P_EXP_SIGN, P_EXP
   } parse_phase_type;

   typedef enum logic [1:0] {ACT_DROP, ACT_ECHO, ACT_ERROR} byte_action_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [8] doc_valid, [15:9] zero
   logic        rsp_tuser;           // is_verdict
   logic        rsp_tlast;           // run_last

   json_validate_compact dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // grammar tracker state
   parse_phase_type parse_at;
   bit              kind_stack [NestMax];   // 1 object, 0 array
   int              open_count;
   int              lit_idx;
   logic [1:0]      lit_sel;
   int              hex_todo;
   bit              bad_doc;

   rsp_item_type pending_out [$];

   logic [7:0] doc_text [$];
   bit         gen_obj [$];
   int         gen_left [$];
   bit         gen_fresh [$];

   logic [7:0] ws_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   string      hex_digits = "0123456789abcdefABCDEF";
   string      esc_chars  = "\"\\/bfnrt";

   bit send_gaps  = 1'b1;
   bit recv_gaps  = 1'b1;
   bit stall_ask  = 1'b0;

   int mismatch_total = 0;
   int docs_sent      = 0;
   int bytes_sent     = 0;
   int random_sent    = 0;
   int echo_total     = 0;
   int valid_total    = 0;
   int invalid_total  = 0;
   int idle_run       = 0;

   function automatic bit is_space(logic [7:0] c);
      return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
   endfunction

   function automatic bit is_hexd(logic [7:0] c);
      return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic string lit_word(logic [1:0] sel);
      case (sel)
         LitTrue:  return "true";
         LitFalse: return "false";
         LitNull:  return "null";
         default:  return "";
      endcase
   endfunction

   task automatic put_byte(logic [7:0] c);
      doc_text.insert(doc_text.size(), c);
   endtask

   task automatic queue_result(rsp_item_type item);
      pending_out.insert(pending_out.size(), item);
   endtask

   task automatic grammar_reset();
      parse_at   = P_VALUE;
      kind_stack = '{default: 1'b0};
      open_count = 0;
      lit_idx    = 0;
      lit_sel    = LitTrue;
      hex_todo   = 0;
      bad_doc    = 1'b0;
   endtask

   function automatic byte_action_type nest_open(bit is_obj);
      if (open_count >= NestMax) return ACT_ERROR;
      kind_stack[open_count] = is_obj;
      open_count++;
      parse_at = is_obj ? P_OBJ_FIRST : P_ARR_FIRST;
      return ACT_ECHO;
   endfunction

   function automatic byte_action_type nest_close(bit is_obj);
      if (open_count == 0 || kind_stack[open_count-1] != is_obj) return ACT_ERROR;
      open_count--;
      parse_at = P_AFTER;
      return ACT_ECHO;
   endfunction

   function automatic byte_action_type value_begin(logic [7:0] c);
      if (is_space(c)) return ACT_DROP;
      case (c)
         ChLbrace: return nest_open(1'b1);
         ChLbrack: return nest_open(1'b0);
         ChQuote: begin
            parse_at = P_VSTR;
            return ACT_ECHO;
         end
         "t", "f", "n": begin
            lit_sel  = (c == "t") ? LitTrue : (c == "f") ? LitFalse : LitNull;
            lit_idx  = 1;
            parse_at = P_LIT;
            return ACT_ECHO;
         end
         ChMinus: begin
            parse_at = P_MINUS;
            return ACT_ECHO;
         end
         ChZero: begin
            parse_at = P_ZERO;
            return ACT_ECHO;
         end
         default: begin
            if (is_num(c)) begin
               parse_at = P_INT;
               return ACT_ECHO;
            end
            return ACT_ERROR;
         end
      endcase
   endfunction

   function automatic byte_action_type value_end(logic [7:0] c);
      parse_at = P_AFTER;
      if (is_space(c)) return ACT_DROP;
      if (open_count == 0) return ACT_ERROR;
      if (c == ChComma) begin
         parse_at = kind_stack[open_count-1] ? P_KEY : P_VALUE;
         return ACT_ECHO;
      end
      if (c == ChRbrack) return nest_close(1'b0);
      if (c == ChRbrace) return nest_close(1'b1);
      return ACT_ERROR;
   endfunction

   function automatic byte_action_type string_step(logic [7:0] c, bit key);
      case (parse_at)
         P_VSTR, P_KSTR: begin
            if (c == ChQuote) begin
               parse_at = key ? P_COLON : P_AFTER;
               return ACT_ECHO;
            end
            if (c == ChBslash) begin
               parse_at = key ? P_KESC : P_VESC;
               return ACT_ECHO;
            end
            return (c < 8'h20) ? ACT_ERROR : ACT_ECHO;
         end
         P_VESC, P_KESC: begin
            case (c)
               ChQuote, ChBslash, ChSlash, "b", "f", "n", "r", "t": begin
                  parse_at = key ? P_KSTR : P_VSTR;
                  return ACT_ECHO;
               end
               "u": begin
                  hex_todo = 3;
                  parse_at = key ? P_KHEX : P_VHEX;
                  return ACT_ECHO;
               end
               default: return ACT_ERROR;
            endcase
         end
         default: begin
            if (!is_hexd(c)) return ACT_ERROR;
            if (hex_todo == 0) parse_at = key ? P_KSTR : P_VSTR;
            else hex_todo--;
            return ACT_ECHO;
         end
      endcase
   endfunction

   function automatic byte_action_type grammar_feed(logic [7:0] c);
      string w;
      case (parse_at)
         P_VALUE: return value_begin(c);
         P_ARR_FIRST: begin
            if (c == ChRbrack) return nest_close(1'b0);
            return value_begin(c);
         end
         P_OBJ_FIRST, P_KEY: begin
            if (parse_at == P_OBJ_FIRST && c == ChRbrace) return nest_close(1'b1);
            if (is_space(c)) return ACT_DROP;
            if (c == ChQuote) begin
               parse_at = P_KSTR;
               return ACT_ECHO;
            end
            return ACT_ERROR;
         end
         P_COLON: begin
            if (is_space(c)) return ACT_DROP;
            if (c == ChColon) begin
               parse_at = P_VALUE;
               return ACT_ECHO;
            end
            return ACT_ERROR;
         end
         P_AFTER: return value_end(c);
         P_VSTR, P_VESC, P_VHEX: return string_step(c, 1'b0);
         P_KSTR, P_KESC, P_KHEX: return string_step(c, 1'b1);
         P_LIT: begin
            w = lit_word(lit_sel);
            if (w.len() == 0 || lit_idx >= w.len()) return ACT_ERROR;
            if (c != w[lit_idx]) return ACT_ERROR;
            lit_idx++;
            if (lit_idx == w.len()) begin
               lit_idx  = 0;
               parse_at = P_AFTER;
            end
            return ACT_ECHO;
         end
         P_MINUS: begin
            if (c == ChZero) begin
               parse_at = P_ZERO;
               return ACT_ECHO;
            end
            if (is_num(c)) begin
               parse_at = P_INT;
               return ACT_ECHO;
            end
            return ACT_ERROR;
         end
         P_ZERO, P_INT: begin
            // no leading zeros
            if (is_num(c)) return (parse_at == P_ZERO) ? ACT_ERROR : ACT_ECHO;
            if (c == ChDot) begin
               parse_at = P_DOT;
               return ACT_ECHO;
            end
            if (c == "e" || c == "E") begin
               parse_at = P_EXP_MARK;
               return ACT_ECHO;
            end
            return value_end(c);
         end
         P_DOT: begin
            if (is_num(c)) begin
               parse_at = P_FRAC;
               return ACT_ECHO;
            end
            return ACT_ERROR;
         end
         P_FRAC: begin
            if (is_num(c)) return ACT_ECHO;
            if (c == "e" || c == "E") begin
               parse_at = P_EXP_MARK;
               return ACT_ECHO;
            end
            return value_end(c);
         end
         P_EXP_MARK, P_EXP_SIGN: begin
            if (parse_at == P_EXP_MARK && (c == ChPlus || c == ChMinus)) begin
               parse_at = P_EXP_SIGN;
               return ACT_ECHO;
            end
            if (is_num(c)) begin
               parse_at = P_EXP;
               return ACT_ECHO;
            end
            return ACT_ERROR;
         end
         P_EXP: begin
            if (is_num(c)) return ACT_ECHO;
            return value_end(c);
         end
         default: return ACT_ERROR;
      endcase
   endfunction

   task automatic predict_beat(logic [7:0] c, bit last);
      byte_action_type r;
      rsp_item_type    item;
      bit              whole;
      if (!bad_doc) begin
         r = grammar_feed(c);
         if (r == ACT_ERROR) begin
            bad_doc = 1'b1;
         end else if (r == ACT_ECHO) begin
            item.out_byte   = c;
            item.is_verdict = 1'b0;
            item.doc_valid  = 1'b0;
            item.run_last   = !last;
            queue_result(item);
            echo_total++;
         end
      end
      if (last) begin
         whole = open_count == 0 &&
                 (parse_at == P_AFTER || parse_at == P_ZERO || parse_at == P_INT ||
                  parse_at == P_FRAC || parse_at == P_EXP);
         item.out_byte   = 8'h00;
         item.is_verdict = 1'b1;
         item.doc_valid  = !bad_doc && whole;
         item.run_last   = 1'b1;
         queue_result(item);
         if (item.doc_valid) valid_total++;
         else invalid_total++;
         grammar_reset();
      end
   endtask

   // entered and left at a falling edge
   task automatic send_byte(logic [7:0] c, bit last);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beat(c, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_doc();
      foreach (doc_text[i]) send_byte(doc_text[i], i == doc_text.size() - 1);
      doc_text.delete();
      docs_sent++;
   endtask

   task automatic add_text(string s);
      foreach (s[i]) put_byte(s[i]);
   endtask

   task automatic send_text(string s);
      add_text(s);
      send_doc();
   endtask

   task automatic push_digit(int lo);
      put_byte(8'(ChZero + $urandom_range(lo, 9)));
   endtask

   task automatic emit_ws();
      repeat ($urandom_range(0, 2)) put_byte(ws_set[$urandom_range(0, 5)]);
   endtask

   task automatic emit_string();
      logic [7:0] c;
      put_byte(ChQuote);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 9))
            5: put_byte(8'($urandom_range(8'h80, 8'hFF)));
            6, 7: begin
               put_byte(ChBslash);
               put_byte(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
            end
            8: begin
               add_text("\\u");
               repeat (4) put_byte(hex_digits[$urandom_range(0, 21)]);
            end
            default: begin
               c = 8'($urandom_range(8'h20, 8'h7E));
               if (c == ChQuote || c == ChBslash) c = "a";
               put_byte(c);
            end
         endcase
      end
      put_byte(ChQuote);
   endtask

   task automatic emit_number();
      if ($urandom_range(0, 3) == 0) put_byte(ChMinus);
      if ($urandom_range(0, 3) == 0) begin
         put_byte(ChZero);
      end else begin
         push_digit(1);
         repeat ($urandom_range(0, 3)) push_digit(0);
      end
      if ($urandom_range(0, 2) == 0) begin
         put_byte(ChDot);
         repeat ($urandom_range(1, 3)) push_digit(0);
      end
      if ($urandom_range(0, 2) == 0) begin
         put_byte($urandom_range(0, 1) ? "e" : "E");
         case ($urandom_range(0, 2))
            0: put_byte(ChPlus);
            1: put_byte(ChMinus);
            default: ;
         endcase
         repeat ($urandom_range(1, 2)) push_digit(0);
      end
   endtask

   // a scalar, or the opening of a container left on the generator stack
   task automatic emit_one(input int budget);
      int k;
      k = $urandom_range(0, budget > 0 ? 9 : 5);
      case (k)
         0, 1: emit_string();
         2, 3, 5: emit_number();
         4: add_text(lit_word(2'($urandom_range(0, 2))));
         default: begin
            put_byte(k >= 8 ? ChLbrace : ChLbrack);
            emit_ws();
            gen_obj.insert(gen_obj.size(), k >= 8);
            gen_left.insert(gen_left.size(), $urandom_range(0, 3));
            gen_fresh.insert(gen_fresh.size(), 1'b1);
         end
      endcase
   endtask

   task automatic emit_value(input int budget);
      int top;
      emit_one(budget);
      while (gen_obj.size() > 0) begin
         top = gen_obj.size() - 1;
         if (gen_left[top] == 0) begin
            emit_ws();
            put_byte(gen_obj[top] ? ChRbrace : ChRbrack);
            gen_obj.pop_back();
            gen_left.pop_back();
            gen_fresh.pop_back();
         end else begin
            if (!gen_fresh[top]) begin
               put_byte(ChComma);
               emit_ws();
            end
            gen_fresh[top] = 1'b0;
            gen_left[top]--;
            if (gen_obj[top]) begin
               emit_string();
               emit_ws();
               put_byte(ChColon);
               emit_ws();
            end
            emit_one(budget - gen_obj.size());
            emit_ws();
         end
      end
   endtask

   task automatic report_mismatch(string note, rsp_item_type want, rsp_item_type got,
                                  logic [6:0] pad);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("%0t %s: expected byte %02h verdict %0b valid %0b last %0b",
                  $realtime, note, want.out_byte, want.is_verdict, want.doc_valid,
                  want.run_last);
         $display("   got byte %02h verdict %0b valid %0b last %0b pad %02h",
                  got.out_byte, got.is_verdict, got.doc_valid, got.run_last, pad);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte   = rsp_tdata[7:0];
         got.is_verdict = rsp_tuser;
         got.doc_valid  = rsp_tdata[8];
         got.run_last   = rsp_tlast;
         if (pending_out.size() == 0) begin
            want = '0;
            report_mismatch("result beat with nothing pending", want, got, rsp_tdata[15:9]);
         end else begin
            want = pending_out.pop_front();
            if (got != want || rsp_tdata[15:9] != 7'd0)
               report_mismatch("result mismatch", want, got, rsp_tdata[15:9]);
         end
      end
   end

   // receiver: random ready bursts, plus one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (stall_ask) begin
            stall_ask = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
         end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   initial begin
      while (idle_run < StallLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_run = 0;
         else idle_run++;
      end
      $display("timeout: %0d cycles without a beat, %0d results pending",
               StallLimit, pending_out.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic test_literals();
      send_text("true");
      send_text(" false ");
      send_text("null");
      send_text("nul");
      send_text("trUe");
      send_text("nulll");
   endtask

   task automatic test_strings();
      send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\\u0aF9z\"");
      send_text("{\"k\\n\\u00e9\":\"v w\"}");
      send_text("\"\\x\"");
      send_text("\"\\u12g4\"");
      // control byte inside a string
      put_byte(ChQuote);
      put_byte(8'h1F);
      put_byte(ChQuote);
      send_doc();
   endtask

   task automatic test_numbers();
      send_text("-0.5e+3");
      send_text("0");
      send_text("42");
      send_text("12E-7 ");
      send_text("3.25");
      send_text("01");
      send_text("-");
      send_text("1.");
      send_text("1e");
      send_text("-x");
   endtask

   task automatic test_containers();
      send_text("{ \"k\" : [1, {}, []] , \"z\":\"s\" }");
      send_text("[}");
      send_text("]");
      send_text("1 x");
      send_text("[1,]");
      send_text("{\"a\" 1}");
      send_text("{,}");
      send_text("[1 2]");
      send_text("{\"a\":1,}");
      send_text("[[1]");
   endtask

   task automatic test_nesting_depth();
      repeat (NestMax) put_byte(ChLbrack);
      repeat (NestMax) put_byte(ChRbrack);
      send_doc();
      repeat (NestMax + 1) put_byte(ChLbrack);
      send_doc();
      send_text("{\"a\":[{\"b\":[]}],\"c\":{}}");
   endtask

   task automatic test_whitespace();
      foreach (ws_set[i]) put_byte(ws_set[i]);
      add_text("[");
      put_byte(8'h0D);
      add_text("1");
      put_byte(8'h09);
      add_text("]");
      foreach (ws_set[i]) put_byte(ws_set[5 - i]);
      send_doc();
      send_text("   ");
      // bytes just outside the whitespace range
      add_text("[");
      put_byte(8'h08);
      add_text("]");
      send_doc();
      add_text("[");
      put_byte(8'h0E);
      add_text("]");
      send_doc();
   endtask

   task automatic test_byte_extremes();
      put_byte(8'h00);
      send_doc();
      put_byte(8'hFF);
      send_doc();
      put_byte(ChQuote);
      put_byte(8'h80);
      put_byte(8'h7F);
      put_byte(8'hFF);
      put_byte(8'h20);
      put_byte(ChQuote);
      send_doc();
   endtask

   // long output stall while input keeps coming: block must backpressure
   task automatic test_backpressure();
      send_gaps = 1'b0;
      stall_ask = 1'b1;
      add_text("[");
      repeat (20) add_text("12,");
      add_text("\"end\"]");
      send_doc();
      send_gaps = 1'b1;
   endtask

   task automatic test_random_docs();
      int         mode;
      int         pos;
      int         n;
      logic [7:0] junk;
      while (random_sent < RandomBytes) begin
         mode = $urandom_range(0, 31);
         if (mode == 0) begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
         end else if (mode == 1) begin
            n = $urandom_range(NestMax - 2, NestMax + 1);
            repeat (n) put_byte(ChLbrack);
            push_digit(0);
            repeat (n) put_byte(ChRbrack);
         end else begin
            emit_ws();
            emit_value($urandom_range(0, 3));
            emit_ws();
            if (mode <= 7) begin
               junk = 8'($urandom_range(0, 255));
               pos  = $urandom_range(0, doc_text.size() - 1);
               case (mode % 3)
                  0: doc_text[pos] = junk;
                  1: if (pos > 0) doc_text = doc_text[0:pos-1];
                  default: doc_text.insert(pos, junk);
               endcase
            end
         end
         random_sent += doc_text.size();
         send_doc();
      end
   endtask

   task automatic test_steady_stream();
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      repeat (6) begin
         emit_ws();
         emit_value(2);
         emit_ws();
         send_doc();
      end
   endtask

   initial begin
      grammar_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_literals();
      test_strings();
      test_numbers();
      test_containers();
      test_nesting_depth();
      test_whitespace();
      test_byte_extremes();
      test_backpressure();
      test_random_docs();
      test_steady_stream();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Ran %0d documents, %0d bytes: %0d valid, %0d invalid, %0d compact bytes.",
               docs_sent, bytes_sent, valid_total, invalid_total, echo_total);
      $display("Grammar corner cases, nesting past depth %0d and a %0d-cycle output stall.",
               NestMax, HoldCycles);
      if (mismatch_total == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_total);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
